[src/lzw_pkg.sv]
// Shared types and constants for the LZW encoder.
// Holds the request structs of both channels and the controller/datapath link.
// No dependencies.
package lzw_pkg;

    // Default dictionary code width and the first code a learned string gets.
    localparam int CODE_WIDTH_DEF  = 12;
    localparam int FIRST_FREE_CODE = 256;

    // Width of the emitted code field.
    localparam int CODE_FIELD_W = 12;

    // One input request: a byte and its end-of-stream flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } lzw_in_t;

    // One result request: an emitted code and its last-code flag.
    typedef struct packed {
        logic [CODE_FIELD_W-1:0] code;
        logic                    last_code;
    } lzw_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic next_probe;
        logic take_hit;
        logic take_miss;
        logic flush;
    } lzw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic prefix_valid;
        logic match;
        logic empty;
        logic eos;
        logic out_free;
    } lzw_stat_t;

endpackage

[src/lzw_dp.sv]
// Datapath of the LZW encoder: prefix state, hash table, code owner store and
// the result register. Depends on lzw_pkg.
// Driven by lzw_ctrl through lzw_cmd_t and reports back through lzw_stat_t.
module lzw_dp #(
    parameter int CODE_WIDTH = lzw_pkg::CODE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lzw_pkg::lzw_in_t   item,
    input  lzw_pkg::lzw_cmd_t  cmd,
    output lzw_pkg::lzw_stat_t stat,
    output logic               result_valid,
    input  logic               result_stall,
    output lzw_pkg::lzw_out_t  result
);
    import lzw_pkg::*;

    // The hash table has twice as many slots as there are codes, so a probe
    // always meets a match or a free slot.
    localparam int SlotWidth  = CODE_WIDTH + 1;
    localparam int SlotDepth  = 1 << SlotWidth;
    localparam int DictDepth  = 1 << CODE_WIDTH;
    localparam int EntryWidth = 2 * CODE_WIDTH + 8;
    localparam logic [CODE_WIDTH:0] FirstFree = (CODE_WIDTH + 1)'(FIRST_FREE_CODE);

    // Slot entry: {code, prefix code, byte}. Owner entry: slot that holds a code.
    logic [EntryWidth-1:0] slot_mem  [SlotDepth];
    logic [SlotWidth-1:0]  owner_mem [DictDepth];

    logic [7:0]            byte_reg, byte_next;
    logic                  eos_reg, eos_next;
    logic [CODE_WIDTH-1:0] prefix_reg, prefix_next;
    logic                  prefix_valid_reg, prefix_valid_next;
    logic [CODE_WIDTH:0]   nfc_reg, nfc_next;
    logic [SlotWidth-1:0]  probe_reg, probe_next;
    logic [SlotWidth-1:0]  clear_idx_reg, clear_idx_next;
    logic                  clear_done_reg, clear_done_next;
    logic [EntryWidth-1:0] slot_rd_reg;
    logic [SlotWidth-1:0]  owner_rd_reg;
    logic                  out_valid_reg, out_valid_next;
    lzw_out_t              out_reg, out_next;

    logic [CODE_WIDTH-1:0]              rd_code;
    logic [CODE_WIDTH-1:0]              rd_prefix;
    logic [7:0]                         rd_byte;
    logic                               live;
    logic                               key_eq;
    logic                               out_free;
    logic                               dict_room;
    logic [SlotWidth-1:0]               hash;
    logic [CODE_WIDTH+CODE_FIELD_W-1:0] prefix_ext;
    logic                               slot_we;
    logic [SlotWidth-1:0]               slot_wa;
    logic [EntryWidth-1:0]              slot_wd;
    logic                               owner_we;

    // Fields of the slot read back for the current probe.
    assign rd_code   = slot_rd_reg[EntryWidth-1 -: CODE_WIDTH];
    assign rd_prefix = slot_rd_reg[CODE_WIDTH+7:8];
    assign rd_byte   = slot_rd_reg[7:0];

    // A slot is live when its code was learned in this stream and that code
    // was placed in this very slot; anything else is a free slot.
    assign live = (rd_code[CODE_WIDTH-1:8] != '0)
               && ({1'b0, rd_code} < nfc_reg)
               && (owner_rd_reg == probe_reg);
    assign key_eq = (rd_prefix == prefix_reg) && (rd_byte == byte_reg);

    assign out_free  = !out_valid_reg || !result_stall;
    assign dict_room = !nfc_reg[CODE_WIDTH];

    // Home slot of (prefix, byte): prefix in the low bits, byte folded on top.
    assign hash = {1'b0, prefix_reg} ^ {item.data_byte, {(SlotWidth - 8){1'b0}}};

    assign prefix_ext = {{CODE_FIELD_W{1'b0}}, prefix_reg};

    // Status toward the controller.
    always_comb
    begin
        stat.clear_done   = clear_done_reg;
        stat.prefix_valid = prefix_valid_reg;
        stat.match        = live && key_eq;
        stat.empty        = !live;
        stat.eos          = eos_reg;
        stat.out_free     = out_free;
    end

    // Write port of the hash table: clearing pass or a newly learned string.
    always_comb
    begin
        slot_we  = (cmd.clear_step && !clear_done_reg) || (cmd.take_miss && dict_room);
        slot_wa  = probe_reg;
        slot_wd  = {nfc_reg[CODE_WIDTH-1:0], prefix_reg, byte_reg};
        if (!clear_done_reg)
        begin
            slot_wa = clear_idx_reg;
            slot_wd = '0;
        end
        owner_we = cmd.take_miss && dict_room;
    end

    // Next-state logic of the datapath registers.
    always_comb
    begin
        byte_next         = byte_reg;
        eos_next          = eos_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        nfc_next          = nfc_reg;
        probe_next        = probe_reg;
        clear_idx_next    = clear_idx_reg;
        clear_done_next   = clear_done_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && result_stall;

        if (cmd.clear_step && !clear_done_reg)
        begin
            clear_idx_next = clear_idx_reg + 1'b1;
            if (clear_idx_reg == '1)
            begin
                clear_done_next = 1'b1;
            end
        end

        if (cmd.accept)
        begin
            byte_next  = item.data_byte;
            eos_next   = item.end_of_stream;
            probe_next = hash;
            if (!prefix_valid_reg)
            begin
                prefix_next       = {{(CODE_WIDTH - 8){1'b0}}, item.data_byte};
                prefix_valid_next = 1'b1;
            end
        end

        if (cmd.next_probe)
        begin
            probe_next = probe_reg + 1'b1;
        end

        if (cmd.take_hit)
        begin
            prefix_next = rd_code;
        end

        // Unknown string: emit the prefix, learn the string if the dictionary has room, restart at the byte.
        if (cmd.take_miss)
        begin
            out_next.code      = prefix_ext[CODE_FIELD_W-1:0];
            out_next.last_code = 1'b0;
            out_valid_next     = 1'b1;
            prefix_next        = {{(CODE_WIDTH - 8){1'b0}}, byte_reg};
            if (dict_room)
            begin
                nfc_next = nfc_reg + 1'b1;
            end
        end

        // End of stream: emit the final prefix and restart the dictionary.
        if (cmd.flush)
        begin
            out_next.code      = prefix_ext[CODE_FIELD_W-1:0];
            out_next.last_code = 1'b1;
            out_valid_next     = 1'b1;
            prefix_next        = '0;
            prefix_valid_next  = 1'b0;
            nfc_next           = FirstFree;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            nfc_reg          <= FirstFree;
            clear_idx_reg    <= '0;
            clear_done_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            nfc_reg          <= nfc_next;
            clear_idx_reg    <= clear_idx_next;
            clear_done_reg   <= clear_done_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        eos_reg   <= eos_next;
        probe_reg <= probe_next;
        out_reg   <= out_next;
    end

    // Hash table: one write, one registered read at the probe slot.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[probe_reg];
    end

    // Owner store: slot of each learned code, read at the code found in the slot.
    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[nfc_reg[CODE_WIDTH-1:0]] <= probe_reg;
        end
        owner_rd_reg <= owner_mem[rd_code];
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[src/lzw_ctrl.sv]
// Controller of the LZW encoder: sequences clearing, probing and result pushes.
// Depends on lzw_pkg; drives lzw_dp through lzw_cmd_t.
module lzw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               data_valid,
    input  lzw_pkg::lzw_stat_t stat,
    output lzw_pkg::lzw_cmd_t  cmd,
    output logic               busy
);
    import lzw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_SLOT,
        ST_READ_OWNER,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (data_valid && !busy_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.prefix_valid ? ST_READ_SLOT : ST_FINISH;
                end
            end
            ST_READ_SLOT:
            begin
                state_next = ST_READ_OWNER;
            end
            ST_READ_OWNER:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.match)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (stat.empty)
                begin
                    if (stat.out_free)
                    begin
                        cmd.take_miss = 1'b1;
                        state_next    = ST_FINISH;
                    end
                end
                else
                begin
                    cmd.next_probe = 1'b1;
                    state_next     = ST_READ_SLOT;
                end
            end
            ST_FINISH:
            begin
                if (!stat.eos)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    // State and the registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

[src/lzw_encoder.sv]
// LZW encoder top level: one byte per input request, codes per result request.
// Depends on lzw_pkg, lzw_ctrl and lzw_dp.
//
// Input channel data_valid/data_stall/data carries a byte and an end-of-stream
// flag. Result channel result_valid/result_stall/result carries a code and a
// flag on the final code of a stream. A byte gives zero, one or two codes.
// The block takes one byte at a time. The first byte of a stream sets the
// prefix without a probe. Any later byte is looked up in the hash table with
// one or more probes, until its string is found or a free slot is met; each probe is
// a slot read followed by a read of the code owner store. A byte that ends a
// stream emits its final code as soon as the result register is free.
// A finished code waits in the result register while the next byte is taken;
// a second code waits until that register frees up, and a stalled receiver
// holds the block in place without losing anything.
// After reset the block clears its hash table, one slot a cycle, over all
// 2^(CODE_WIDTH+1) slots (8192 at the default width); data_stall falls after
// the clear-done flag, then the controller state and busy flag, are registered.
// The dictionary restarts after each end-of-stream byte.
module lzw_encoder #(
    parameter int CODE_WIDTH = lzw_pkg::CODE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              data_valid,
    output logic              data_stall,
    input  lzw_pkg::lzw_in_t  data,
    output logic              result_valid,
    input  logic              result_stall,
    output lzw_pkg::lzw_out_t result
);
    import lzw_pkg::*;

    lzw_cmd_t  cmd;
    lzw_stat_t stat;
    logic      busy;

    // Controller.
    lzw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    // Datapath.
    lzw_dp #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign data_stall = busy;

`ifndef SYNTHESIS
    // No byte is taken before the clearing pass has finished.
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.clear_done |-> data_stall)
        else $error("byte accepted during clearing pass");

    // A code is pushed only when the result register is free.
    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_miss || cmd.flush) |-> stat.out_free)
        else $error("result register overwritten");

    // Each accepted byte keeps the input stalled while it is worked on.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (data_valid && !data_stall) |=> data_stall)
        else $error("input not stalled after accepting a byte");
`endif

endmodule
